/* design/ioi_pkg.sv */
// Shared types and constants for the interval overlay insert block.
// No dependencies; ioi_split and interval_overlay_insert refer to this package by scoped name.
package ioi_pkg;

  localparam int COL_BITS      = 16;
  localparam int TAG_BITS      = 8;
  localparam int MAX_SPANS_DEF = 32;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY_SPAN = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [COL_BITS-1:0] span_start;
    logic [COL_BITS-1:0] span_end;
    logic [TAG_BITS-1:0] span_tag;
  } item_in_t;

  typedef struct packed {
    logic                entry_valid;
    logic [COL_BITS-1:0] entry_start;
    logic [COL_BITS-1:0] entry_end;
    logic [TAG_BITS-1:0] entry_tag;
    logic [1:0]          status;
    logic                last_entry;
  } item_out_t;

  typedef struct packed {
    logic [COL_BITS-1:0] col_lo;
    logic [COL_BITS-1:0] col_hi;
    logic [TAG_BITS-1:0] tag;
  } span_t;

  typedef struct packed {
    logic       we;
    span_t      wdata;
    logic       set_new;
    logic       advance;
    logic [1:0] ph_next;
  } walk_act_t;

endpackage

/* design/ioi_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ioi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ioi_split.sv */
// Per-span rewrite step: picks the next left remnant, new span or right remnant to write.
// Depends on ioi_pkg.
module ioi_split (
  input  ioi_pkg::span_t                   cur,
  input  logic [ioi_pkg::COL_BITS-1:0]     ins_lo,
  input  logic [ioi_pkg::COL_BITS-1:0]     ins_hi,
  input  logic [ioi_pkg::TAG_BITS-1:0]     ins_tag,
  input  logic [1:0]                       ph,
  input  logic                             new_done,
  output ioi_pkg::walk_act_t               act
);

  logic sl, sr, sn, a0, a1, a2;

  assign sl = cur.col_lo < ins_lo;
  assign sr = cur.col_hi > ins_hi;
  assign sn = sr && !new_done;
  assign a0 = (ph == 2'd0) && sl;
  assign a1 = (ph <= 2'd1) && sn;
  assign a2 = (ph <= 2'd2) && sr;

  always_comb begin
    act = '0;
    if (a0) begin
      act.we           = 1'b1;
      act.wdata.col_lo = cur.col_lo;
      act.wdata.col_hi = (cur.col_hi < ins_lo) ? cur.col_hi : ins_lo;
      act.wdata.tag    = cur.tag;
      act.advance      = !(a1 || a2);
      act.ph_next      = 2'd1;
    end else if (a1) begin
      act.we           = 1'b1;
      act.wdata.col_lo = ins_lo;
      act.wdata.col_hi = ins_hi;
      act.wdata.tag    = ins_tag;
      act.set_new      = 1'b1;
      act.advance      = !a2;
      act.ph_next      = 2'd2;
    end else if (a2) begin
      act.we           = 1'b1;
      act.wdata.col_lo = (cur.col_lo > ins_hi) ? cur.col_lo : ins_hi;
      act.wdata.col_hi = cur.col_hi;
      act.wdata.tag    = cur.tag;
      act.advance      = 1'b1;
      act.ph_next      = 2'd3;
    end else begin
      act.advance      = 1'b1;
    end
  end

endmodule

/* design/interval_overlay_insert.sv */
// Top level of the interval overlay insert block: sequencer, span store, result port.
// Depends on ioi_pkg, ioi_ram and ioi_split.
//
//   channel   handshake               payload
//   command   start / busy            cmd    (item_in_t)
//   result    result_strobe           result (item_out_t)
//
// An insert walks the stored list once (skipped on an empty list), writing each
// left remnant, the new span and the far half of a split into the other bank;
// S_FIN writes the new span if still pending, then one beat per cycle is emitted.
// A clear emits one empty beat; a refused empty span re-emits the stored list,
// or one empty beat when the list is empty.
// The list lives in two banks of one RAM; an insert that fits swaps banks, a refused one does not.
// Reset empties the list. The receiver cannot stall; busy holds off commands.
module interval_overlay_insert #(
  parameter int MAX_SPANS = ioi_pkg::MAX_SPANS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ioi_pkg::item_in_t  cmd,
  output logic               result_strobe,
  output ioi_pkg::item_out_t result
);

  localparam int IW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CW = $clog2(MAX_SPANS + 1);
  localparam int WW = $clog2(2 * MAX_SPANS + 2);
  localparam int DW = $bits(ioi_pkg::span_t);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_FIN   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_EMPTY = 5'b10000
  } state_t;

  state_t                       state;
  ioi_pkg::item_in_t            item;
  logic                         bank;
  logic                         ebank;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                ecnt;
  logic [CW-1:0]                k;
  logic [CW-1:0]                j;
  logic [WW-1:0]                wn;
  logic [1:0]                   ph;
  logic                         new_done;
  logic [1:0]                   st;
  logic                         last;
  logic                         empty;
  logic [CW-1:0]                k_next;
  logic [WW-1:0]                total;
  logic                         we;
  logic [IW:0]                  waddr;
  logic [IW:0]                  raddr;
  ioi_pkg::span_t               wdata;
  ioi_pkg::span_t               rdata;
  ioi_pkg::walk_act_t           act;

  ioi_split u_split (
    .cur      (rdata),
    .ins_lo   (item.span_start),
    .ins_hi   (item.span_end),
    .ins_tag  (item.span_tag),
    .ph       (ph),
    .new_done (new_done),
    .act      (act)
  );

  ioi_ram #(
    .WIDTH (DW),
    .DEPTH (2 * (1 << IW))
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign k_next = k + CW'(1);
  assign total  = new_done ? wn : wn + WW'(1);

  always_comb begin
    raddr = {bank, IW'(0)};
    case (state)
      S_WALK:  raddr = {bank, act.advance ? k_next[IW-1:0] : k[IW-1:0]};
      S_EMIT:  raddr = {ebank, j[IW-1:0]};
      default: raddr = {bank, IW'(0)};
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = act.wdata;
    waddr = {~bank, wn[IW-1:0]};
    if (state == S_WALK) begin
      we = act.we && (wn < WW'(MAX_SPANS));
    end else if (state == S_FIN) begin
      we                = !new_done && (wn < WW'(MAX_SPANS));
      wdata.col_lo      = item.span_start;
      wdata.col_hi      = item.span_end;
      wdata.tag         = item.span_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bank          <= 1'b0;
      cnt           <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == S_EMIT) || (state == S_EMPTY);
      case (state)
        S_IDLE: begin
          if (start) begin
            item     <= cmd;
            k        <= '0;
            j        <= '0;
            wn       <= '0;
            ph       <= 2'd0;
            new_done <= 1'b0;
            ebank    <= bank;
            ecnt     <= cnt;
            if (cmd.operation == ioi_pkg::OP_CLEAR) begin
              cnt   <= '0;
              st    <= ioi_pkg::ST_OK;
              state <= S_EMPTY;
            end else if (cmd.span_start >= cmd.span_end) begin
              st    <= ioi_pkg::ST_EMPTY_SPAN;
              state <= (cnt == '0) ? S_EMPTY : S_EMIT;
            end else begin
              state <= (cnt == '0) ? S_FIN : S_WALK;
            end
          end
        end
        S_WALK: begin
          if (act.we) begin
            wn <= wn + WW'(1);
          end
          if (act.set_new) begin
            new_done <= 1'b1;
          end
          if (act.advance) begin
            k  <= k_next;
            ph <= 2'd0;
            if (k_next == cnt) begin
              state <= S_FIN;
            end
          end else begin
            ph <= act.ph_next;
          end
        end
        S_FIN: begin
          if (total > WW'(MAX_SPANS)) begin
            st    <= ioi_pkg::ST_FULL;
            ebank <= bank;
            ecnt  <= cnt;
            state <= (cnt == '0) ? S_EMPTY : S_EMIT;
          end else begin
            st    <= ioi_pkg::ST_OK;
            bank  <= ~bank;
            ebank <= ~bank;
            cnt   <= total[CW-1:0];
            ecnt  <= total[CW-1:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          empty         <= 1'b0;
          last          <= (j + CW'(1) == ecnt);
          j             <= j + CW'(1);
          if (j + CW'(1) == ecnt) begin
            state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          empty         <= 1'b1;
          last          <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    result.entry_valid = !empty;
    result.entry_start = empty ? '0 : rdata.col_lo;
    result.entry_end   = empty ? '0 : rdata.col_hi;
    result.entry_tag   = empty ? '0 : rdata.tag;
    result.status      = st;
    result.last_entry  = last;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_SPANS))
    else $error("span count above capacity");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last_entry |=> !result_strobe)
    else $error("beat follows last beat of a run");

  a_walk_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_FIN) |-> !result_strobe)
    else $error("beat emitted while rewriting list");

  a_refuse_keeps: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && total > WW'(MAX_SPANS) |=> $stable(bank))
    else $error("bank swapped on refused insert");

endmodule

/* verif/tb_interval_overlay_insert.sv */
// Self-checking testbench for interval_overlay_insert: span inserts with overwrite, and clears.
// Predicts each list run from its own span list model and compares every result beat.
// Depends on ioi_pkg and the interval_overlay_insert RTL.
`timescale 1ns / 100ps

module tb_interval_overlay_insert;

  localparam int CAP = ioi_pkg::MAX_SPANS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  ioi_pkg::item_in_t  cmd = '0;
  logic               result_strobe;
  ioi_pkg::item_out_t result;

  interval_overlay_insert dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .result_strobe(result_strobe), .result(result)
  );

  always #6 clk = ~clk;

  ioi_pkg::span_t     list_q[$];
  ioi_pkg::item_in_t  pending_q[$];
  ioi_pkg::item_out_t expected_q[$];
  int                 fail_cnt = 0;
  int                 idle_pct = 30;
  bit                 hold_send = 1'b0;
  int                 quiet_cycles = 0;

  function automatic ioi_pkg::item_out_t list_beat(bit valid, ioi_pkg::span_t sp,
                                                   logic [1:0] st, bit last);
    ioi_pkg::item_out_t r;
    r.entry_valid = valid;
    r.entry_start = valid ? sp.col_lo : '0;
    r.entry_end   = valid ? sp.col_hi : '0;
    r.entry_tag   = valid ? sp.tag : '0;
    r.status      = st;
    r.last_entry  = last;
    return r;
  endfunction

  function automatic void add_item(ioi_pkg::item_in_t it);
    pending_q = {pending_q, it};
  endfunction

  task automatic predict_list(ioi_pkg::item_in_t it);
    ioi_pkg::span_t merged[$];
    ioi_pkg::span_t sp;
    logic [1:0]     st;
    st = ioi_pkg::ST_OK;
    if (it.operation == ioi_pkg::OP_CLEAR) begin
      list_q.delete();
    end else if (it.span_start >= it.span_end) begin
      st = ioi_pkg::ST_EMPTY_SPAN;
    end else begin
      foreach (list_q[k])
        if (list_q[k].col_lo < it.span_start) begin
          sp = list_q[k];
          if (sp.col_hi > it.span_start) sp.col_hi = it.span_start;
          merged = {merged, sp};
        end
      sp.col_lo = it.span_start;
      sp.col_hi = it.span_end;
      sp.tag    = it.span_tag;
      merged = {merged, sp};
      foreach (list_q[k])
        if (list_q[k].col_hi > it.span_end) begin
          sp = list_q[k];
          if (sp.col_lo < it.span_end) sp.col_lo = it.span_end;
          merged = {merged, sp};
        end
      if (merged.size() > CAP) st = ioi_pkg::ST_FULL;
      else list_q = merged;
    end
    if (list_q.size() == 0) begin
      sp = '0;
      expected_q = {expected_q, list_beat(1'b0, sp, st, 1'b1)};
    end else
      foreach (list_q[k])
        expected_q = {expected_q, list_beat(1'b1, list_q[k], st, k == list_q.size() - 1)};
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_list(cmd);
      if (start && busy) begin
        // hold
      end else if (pending_q.size() > 0 && !hold_send && $urandom_range(99) >= idle_pct) begin
        cmd   <= pending_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ioi_pkg::item_out_t exp_beat;
    if (!rst && result_strobe) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat %p", result);
        fail_cnt++;
      end else begin
        exp_beat = expected_q.pop_front();
        if (result.entry_valid !== exp_beat.entry_valid) begin
          $error("entry_valid exp %0d got %0d", exp_beat.entry_valid, result.entry_valid);
          fail_cnt++;
        end
        if (result.entry_start !== exp_beat.entry_start) begin
          $error("entry_start exp %0d got %0d", exp_beat.entry_start, result.entry_start);
          fail_cnt++;
        end
        if (result.entry_end !== exp_beat.entry_end) begin
          $error("entry_end exp %0d got %0d", exp_beat.entry_end, result.entry_end);
          fail_cnt++;
        end
        if (result.entry_tag !== exp_beat.entry_tag) begin
          $error("entry_tag exp %0d got %0d", exp_beat.entry_tag, result.entry_tag);
          fail_cnt++;
        end
        if (result.status !== exp_beat.status) begin
          $error("status exp %0d got %0d", exp_beat.status, result.status);
          fail_cnt++;
        end
        if (result.last_entry !== exp_beat.last_entry) begin
          $error("last_entry exp %0d got %0d", exp_beat.last_entry, result.last_entry);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_interval_overlay_insert: FAIL");
      $finish;
    end
  end

  function automatic ioi_pkg::item_in_t make_cmd(logic op, int s, int e, int tg);
    ioi_pkg::item_in_t it;
    it.operation  = op;
    it.span_start = s[ioi_pkg::COL_BITS-1:0];
    it.span_end   = e[ioi_pkg::COL_BITS-1:0];
    it.span_tag   = tg[ioi_pkg::TAG_BITS-1:0];
    return it;
  endfunction

  task automatic queue_random(int count, int base, int range);
    int s, w, r;
    repeat (count) begin
      r = $urandom_range(99);
      s = base + $urandom_range(range);
      w = $urandom_range(1, 40);
      if (r < 3)
        add_item(make_cmd(ioi_pkg::OP_CLEAR, $urandom, $urandom, $urandom));
      else if (r < 8)
        add_item(make_cmd(ioi_pkg::OP_INSERT, s, s - $urandom_range(3), $urandom));
      else if (r < 13)
        add_item(make_cmd(ioi_pkg::OP_INSERT, $urandom, $urandom, $urandom));
      else if (r < 18)
        add_item(make_cmd(ioi_pkg::OP_INSERT, base, base + range + 50, $urandom));
      else
        add_item(make_cmd(ioi_pkg::OP_INSERT, s, (s + w) & 16'hffff, $urandom));
    end
  endtask

  task automatic drain_wait();
    while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed: empty list, refusals, split, trims, extremes
    add_item(make_cmd(ioi_pkg::OP_INSERT, 10, 10, 8'h11));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 20, 5, 8'h22));
    add_item(make_cmd(ioi_pkg::OP_CLEAR, 16'hffff, 16'hffff, 8'hff));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 0, 16'hffff, 8'hff));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 100, 200, 8'h00));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 50, 150, 8'h55));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 180, 300, 8'haa));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 120, 190, 8'h33));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 0, 16'hffff, 8'h01));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 16'hfffe, 16'hffff, 8'h80));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 16'hffff, 0, 8'h7f));
    add_item(make_cmd(ioi_pkg::OP_CLEAR, 0, 0, 0));
    for (int i = 0; i < CAP; i++)
      add_item(make_cmd(ioi_pkg::OP_INSERT, i * 4, i * 4 + 2, i));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 200, 202, 8'hee));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 9, 10, 8'hdd));
    add_item(make_cmd(ioi_pkg::OP_INSERT, 0, 2, 8'hcc));
    drain_wait();
    // pause until all results are in, then go on
    hold_send = 1'b1;
    repeat (40) @(posedge clk);
    hold_send = 1'b0;
    queue_random(100, 0, 400);
    add_item(make_cmd(ioi_pkg::OP_CLEAR, 0, 0, 0));
    drain_wait();
    // no idling stretch
    idle_pct = 0;
    queue_random(80, 1000, 300);
    drain_wait();
    idle_pct = 30;
    queue_random(100, 16'hfe00, 16'h1ff);
    drain_wait();
    repeat (80) @(posedge clk);
    if (fail_cnt == 0 && expected_q.size() == 0)
      $display("tb_interval_overlay_insert: PASS");
    else
      $display("tb_interval_overlay_insert: FAIL");
    $finish;
  end

endmodule
